// ===== rtl/pyd_pkg.sv =====
package pyd_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int LEVELS_DEF    = 4;
	localparam int FRAME_W_RST   = 640;
	localparam int FRAME_H_RST   = 480;
	localparam int LEVELS_RST    = 4;
	localparam int HEIGHT_CAP    = 4096;
	localparam int RES_CAP       = 16;
	localparam int FIFO_DEPTH    = 8;
	localparam int LVL_BITS      = 3;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_LEVELS = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_EVEN,
		OP_COPY,
		OP_HOLD
	} take_op_t;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [2:0]  levels_in_use;
		logic        restart;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  level;
		logic [10:0] row;
		logic [10:0] col;
		logic [7:0]  value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic                valid;
		logic                emit;
		logic                last;
		logic [LVL_BITS-1:0] lvl;
		logic                j;
		logic [10:0]         row;
		logic [10:0]         col;
		take_op_t            op;
		logic                avg;
		logic                held;
		logic                nn;
		logic [7:0]          pix;
	} item_t;

endpackage

// ===== rtl/image_pyramid_downsampler.sv =====
// channel   handshake                    payload
// pixel     pixel_valid / pixel_ready    pixel
// result    result_valid / result_ready  level, out_row, out_col, value, last_of_run
// config    apb write at psel&penable&pwrite  paddr, pwdata (reads on prdata)
//
// a pixel is taken only when the scheduler is idle; the scheduler then walks the level
// cascade one word a cycle while the queue has room; the line-store read is registered
// results are written to an 8-entry queue; the scheduler stalls while it is nearly full
// reset clears the level counters and the queue; the line store needs no clearing
// a write to the width, height or levels register restarts the frame counters
module image_pyramid_downsampler #(
	parameter int MAX_WIDTH = pyd_pkg::MAX_WIDTH_DEF,
	parameter int LEVELS    = pyd_pkg::LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  pixel,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  level,
	output logic [10:0] out_row,
	output logic [10:0] out_col,
	output logic [7:0]  value,
	output logic        last_of_run
);
	import pyd_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic [12:0] frame_width_q, frame_height_q;
	logic [2:0]  levels_q;
	logic        restart;
	logic        wr;
	cfg_t        cfg;
	logic        room, res_valid;
	item_t       item_s2;
	result_t     res, head;
	logic [AW-1:0] rd_addr, addr_s2;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign restart = wr && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT ||
		paddr[3:2] == REG_LEVELS);

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH:  prdata = {19'd0, frame_width_q};
			REG_HEIGHT: prdata = {19'd0, frame_height_q};
			REG_LEVELS: prdata = {29'd0, levels_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 13'(FRAME_W_RST);
			frame_height_q <= 13'(FRAME_H_RST);
			levels_q       <= 3'(LEVELS_RST);
		end else begin
			if (wr) begin
				unique case (paddr[3:2])
					REG_WIDTH: begin
						frame_width_q <= pwdata[12:0];
					end
					REG_HEIGHT: begin
						frame_height_q <= pwdata[12:0];
					end
					REG_LEVELS: begin
						levels_q <= pwdata[2:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg.frame_width   = frame_width_q;
	assign cfg.frame_height  = frame_height_q;
	assign cfg.levels_in_use = levels_q;
	assign cfg.restart       = restart;

	pyd_sched #(
		.MAX_WIDTH(MAX_WIDTH),
		.LEVELS(LEVELS)
	) u_sched (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pixel_valid(pixel_valid),
		.pixel(pixel),
		.pixel_ready(pixel_ready),
		.room(room),
		.rd_addr(rd_addr),
		.addr_s2(addr_s2),
		.item_s2(item_s2)
	);

	pyd_datapath #(
		.MAX_WIDTH(MAX_WIDTH),
		.LEVELS(LEVELS)
	) u_datapath (
		.clk(clk),
		.item_s2(item_s2),
		.rd_addr(rd_addr),
		.addr_s2(addr_s2),
		.res_valid(res_valid),
		.res(res)
	);

	pyd_out_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(res_valid),
		.wr_data(res),
		.room(room),
		.rd_valid(result_valid),
		.rd_ready(result_ready),
		.rd_data(head)
	);

	assign level       = head.level;
	assign out_row     = head.row;
	assign out_col     = head.col;
	assign value       = head.value;
	assign last_of_run = head.last;

endmodule

// ===== rtl/pyd_sched.sv =====
module pyd_sched #(
	parameter int MAX_WIDTH = pyd_pkg::MAX_WIDTH_DEF,
	parameter int LEVELS    = pyd_pkg::LEVELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pyd_pkg::cfg_t                cfg,
	input  logic                         pixel_valid,
	input  logic [7:0]                   pixel,
	output logic                         pixel_ready,
	input  logic                         room,
	output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	output logic [$clog2(MAX_WIDTH)-1:0] addr_s2,
	output pyd_pkg::item_t               item_s2
);
	import pyd_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int LW = $clog2(LEVELS);
	localparam int KW = $clog2(LEVELS + 1);

	logic [11:0]   row_q [LEVELS];
	logic [AW-1:0] col_q [LEVELS];
	logic          busy_q;
	logic [LW-1:0] k_q;
	logic          j_q;
	logic          two_q;
	logic [1:0]    nn_q;
	logic [4:0]    nres_q;

	logic [EW-1:0] effw, wk, nc;
	logic [12:0]   effh, hk, nr;
	logic [KW-1:0] nlev, lvk;
	logic [LW-1:0] k;
	logic          j, two;
	logic [1:0]    nn, nn_next, p;
	logic [4:0]    nres;
	logic          item_valid, fire;
	logic [11:0]   r, ro;
	logic [AW-1:0] c, q;
	logic          col_end, row_end, take_on, even, avg, held, odd, last_in_level, done;
	logic          emit, last;
	take_op_t      op;
	logic [AW:0]   maxw, base;

	always_comb begin
		effw = ({1'b0, cfg.frame_width} > 14'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(cfg.frame_width);
		effh = (cfg.frame_height > 13'(HEIGHT_CAP)) ? 13'(HEIGHT_CAP) : cfg.frame_height;
		if (cfg.levels_in_use == 3'd0) begin
			nlev = KW'(1);
		end else if (32'(cfg.levels_in_use) > LEVELS) begin
			nlev = KW'(LEVELS);
		end else begin
			nlev = KW'(cfg.levels_in_use);
		end

		k    = busy_q ? k_q : '0;
		j    = busy_q ? j_q : 1'b0;
		two  = busy_q ? two_q : 1'b0;
		nn   = busy_q ? nn_q : 2'd0;
		nres = busy_q ? nres_q : 5'd0;
		item_valid = busy_q || pixel_valid;
		fire = item_valid && room;

		r  = row_q[k];
		c  = col_q[k];
		wk = effw >> k;
		hk = effh >> k;
		col_end = ((EW+1)'(c) + (EW+1)'(1)) >= (EW+1)'(wk);
		row_end = (13'(r) + 13'd1) >= hk;

		lvk = KW'(k) + KW'(1);
		nc  = effw >> lvk;
		nr  = effh >> lvk;
		take_on = (lvk < nlev) && (nc != '0) && (nr != '0);
		q  = c >> 1;
		ro = r >> 1;

		even = take_on && !r[0] && !c[0] && ((EW+1)'(q) < (EW+1)'(nc));
		avg  = even && (r >= 12'd2) && (q != '0) && (13'(ro) < nr);
		held = avg && ((EW+1)'(q) == ((EW+1)'(nc) - (EW+1)'(1)));
		odd  = take_on && r[0] && c[0] && (13'(ro) < nr) && ((EW+1)'(q) < (EW+1)'(nc));

		op = OP_NONE;
		p  = {1'b0, avg} + {1'b0, held};
		if (even) begin
			op = OP_EVEN;
		end else if (odd) begin
			if (13'(ro) == nr - 13'd1) begin
				op = OP_COPY;
				p  = 2'd1;
			end else if ((EW+1)'(q) == ((EW+1)'(nc) - (EW+1)'(1))) begin
				if (nc == EW'(1)) begin
					op = OP_COPY;
					p  = 2'd1;
				end else begin
					op = OP_HOLD;
				end
			end
		end

		maxw = (AW+1)'(MAX_WIDTH);
		base = maxw - (maxw >> (lvk - KW'(1)));
		rd_addr = base[AW-1:0] + q;

		nn_next = nn + p;
		last_in_level = (j == two);
		done = last_in_level && (nn_next == 2'd0);
		emit = (k != '0) && (nres < 5'(RES_CAP));
		last = emit && (done || (nres == 5'(RES_CAP - 1)));

		pixel_ready = room && !busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				row_q[i] <= '0;
				col_q[i] <= '0;
			end
			busy_q  <= 1'b0;
			k_q     <= '0;
			j_q     <= 1'b0;
			two_q   <= 1'b0;
			nn_q    <= 2'd0;
			nres_q  <= 5'd0;
			item_s2 <= '0;
			addr_s2 <= '0;
		end else begin
			item_s2.valid <= fire;
			item_s2.emit  <= emit;
			item_s2.last  <= last;
			item_s2.lvl   <= LVL_BITS'(k);
			item_s2.j     <= j;
			item_s2.row   <= 11'(r);
			item_s2.col   <= 11'(c);
			item_s2.op    <= op;
			item_s2.avg   <= avg;
			item_s2.held  <= held;
			item_s2.nn    <= nn[0];
			item_s2.pix   <= pixel;
			addr_s2       <= rd_addr;
			if (cfg.restart) begin
				for (int i = 0; i < LEVELS; i++) begin
					row_q[i] <= '0;
					col_q[i] <= '0;
				end
			end else if (fire) begin
				if (col_end) begin
					col_q[k] <= '0;
					row_q[k] <= row_end ? 12'd0 : r + 12'd1;
				end else begin
					col_q[k] <= c + AW'(1);
				end
				busy_q <= !done;
				nres_q <= nres + {4'd0, emit};
				if (!last_in_level) begin
					k_q   <= k;
					j_q   <= 1'b1;
					two_q <= two;
					nn_q  <= nn_next;
				end else begin
					k_q   <= LW'(lvk);
					j_q   <= 1'b0;
					two_q <= (nn_next == 2'd2);
					nn_q  <= 2'd0;
				end
			end
		end
	end

endmodule

// ===== rtl/pyd_datapath.sv =====
module pyd_datapath #(
	parameter int MAX_WIDTH = pyd_pkg::MAX_WIDTH_DEF,
	parameter int LEVELS    = pyd_pkg::LEVELS_DEF
) (
	input  logic                         clk,
	input  pyd_pkg::item_t               item_s2,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic [$clog2(MAX_WIDTH)-1:0] addr_s2,
	output logic                         res_valid,
	output pyd_pkg::result_t             res
);
	import pyd_pkg::*;

	localparam int LW = $clog2(LEVELS);

	logic [7:0] mem [MAX_WIDTH];
	logic [7:0] rdata_s2;
	logic [7:0] vals_q [2][2];
	logic [7:0] prior_top_q [LEVELS];
	logic [7:0] prior_cur_q [LEVELS];
	logic [7:0] held_q [LEVELS];

	logic [7:0]    v, avgv;
	logic [9:0]    sum;
	logic [LW-1:0] lvp;
	logic          nb;

	always_comb begin
		v    = (item_s2.lvl == '0) ? item_s2.pix : vals_q[item_s2.lvl[0]][item_s2.j];
		lvp  = LW'(item_s2.lvl + LVL_BITS'(1));
		nb   = ~item_s2.lvl[0];
		sum  = 10'(prior_top_q[lvp]) + 10'(prior_cur_q[lvp]) + 10'(rdata_s2) + 10'(v);
		avgv = sum[9:2];
		res_valid = item_s2.valid && item_s2.emit;
		res.level = 2'(item_s2.lvl);
		res.row   = item_s2.row;
		res.col   = item_s2.col;
		res.value = v;
		res.last  = item_s2.last;
	end

	always_ff @(posedge clk) begin
		rdata_s2 <= mem[rd_addr];
		if (item_s2.valid) begin
			unique case (item_s2.op)
				OP_EVEN: begin
					mem[addr_s2]     <= v;
					prior_top_q[lvp] <= rdata_s2;
					prior_cur_q[lvp] <= v;
					if (item_s2.avg) begin
						vals_q[nb][item_s2.nn] <= avgv;
					end
					if (item_s2.held) begin
						vals_q[nb][~item_s2.nn] <= held_q[lvp];
					end
				end
				OP_COPY: begin
					vals_q[nb][item_s2.nn] <= v;
				end
				OP_HOLD: begin
					held_q[lvp] <= v;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/pyd_out_fifo.sv =====
module pyd_out_fifo #(
	parameter int DEPTH = pyd_pkg::FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	input  pyd_pkg::result_t wr_data,
	output logic             room,
	output logic             rd_valid,
	input  logic             rd_ready,
	output pyd_pkg::result_t rd_data
);
	import pyd_pkg::*;

	localparam int PW = $clog2(DEPTH);

	result_t       mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          pop;

	assign rd_valid = (count_q != '0);
	assign rd_data  = mem[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;
	assign room     = (count_q <= (PW+1)'(DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (PW+1)'(wr_valid) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule
